### rtl/core/fat_boot_sector_geometry_check_assert.svh
// ----------------------------------------------------------------------------
// FAT boot sector geometry check assertion macros
// Shared assertion macros, clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef FAT_BOOT_SECTOR_GEOMETRY_CHECK_ASSERT_SVH
`define FAT_BOOT_SECTOR_GEOMETRY_CHECK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBSGC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FBSGC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/fbsgc_pkg.sv
// ----------------------------------------------------------------------------
// FAT boot sector geometry check package
// Beat types, stage types and constants shared by the check pipeline.
// ----------------------------------------------------------------------------
package fbsgc_pkg;

   localparam logic [15:0] SIG_WORD    = 16'hAA55;
   localparam logic [15:0] SECTOR_512  = 16'd512;
   localparam logic [15:0] SECTOR_1024 = 16'd1024;
   localparam logic [15:0] SECTOR_2048 = 16'd2048;
   localparam logic [15:0] SECTOR_4096 = 16'd4096;
   localparam int          DIR_ENTRY_SHIFT = 5;
   localparam logic [31:0] FAT12_LIMIT = 32'd4085;
   localparam logic [31:0] FAT16_LIMIT = 32'd65525;

   typedef enum logic [1:0] {
      VARIANT_FAT12 = 2'd0,
      VARIANT_FAT16 = 2'd1,
      VARIANT_FAT32 = 2'd2
   } fat_variant_type;

   typedef struct packed {
      logic [15:0] boot_signature;
      logic [15:0] bytes_per_sector;
      logic [7:0]  sectors_per_cluster;
      logic [15:0] reserved_sectors;
      logic [7:0]  fat_count;
      logic [15:0] root_entries;
      logic [15:0] fat_size_short;
      logic [31:0] fat_size_long;
      logic [15:0] total_short;
      logic [31:0] total_long;
   } req_type;

   typedef struct packed {
      logic            volume_ok;
      fat_variant_type fat_variant;
      logic [12:0]     root_dir_sectors;
      logic [31:0]     fat_sectors;
      logic [31:0]     total_sectors;
      logic [31:0]     data_sectors;
      logic [31:0]     data_clusters;
   } rsp_type;

   typedef struct packed {
      logic        good;
      logic [12:0] root;
      logic [31:0] fat;
      logic [31:0] fat_mult;
      logic [31:0] tot;
      logic [15:0] rsv;
      logic [2:0]  spc_shift;
   } s1_type;

   typedef struct packed {
      logic        good;
      logic [12:0] root;
      logic [31:0] fat;
      logic [31:0] tot;
      logic [31:0] meta;
      logic [2:0]  spc_shift;
   } s2_type;

   typedef struct packed {
      logic        good;
      logic [12:0] root;
      logic [31:0] fat;
      logic [31:0] tot;
      logic [31:0] data;
      logic [31:0] clus;
   } s3_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
   } span_ctl_type;

endpackage

### rtl/core/fat_boot_sector_geometry_check.sv
// ----------------------------------------------------------------------------
// FAT boot sector geometry check
// Validates one FAT boot parameter block per beat and reports its geometry.
//
// The req channel carries one parameter block per beat; the rsp channel
// returns one result beat for each request beat, in order. A beat moves at a
// rising edge where valid is high and stall is low.
// An accepted request beat passes through the stage registers in order: a field
// check stage, a metadata sum stage, a data span and cluster shift stage,
// and the classify stage that is also the result register.
// Throughput is one beat per cycle while rsp_stall is low; the four stage
// registers and the chain of per-stage load enables set that figure.
// Synchronous reset empties every stage; rsp_valid is low after reset.
// While rsp_stall is high the result beat holds, and the pipeline keeps
// filling its empty stages; req_stall rises only when all four are full.
// A failed check gives volume_ok low with every other field zero.
// ----------------------------------------------------------------------------
module fat_boot_sector_geometry_check (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fbsgc_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fbsgc_pkg::rsp_type rsp_payload
);
   import fbsgc_pkg::*;

   `include "fat_boot_sector_geometry_check_assert.svh"

   logic         s1_valid;
   s1_type       s1_data;
   logic         s2_valid;
   logic         s3_valid;
   s3_type       s3_data;
   logic         load1;
   logic         load4;
   span_ctl_type span_ctl;

   always_comb begin
      load4           = !rsp_valid || !rsp_stall;
      span_ctl.load_b = !s3_valid || load4;
      span_ctl.load_a = !s2_valid || span_ctl.load_b;
      load1           = !s1_valid || span_ctl.load_a;
   end

   assign req_stall = !load1;

   fbsgc_check u_check (
      .clock       (clock),
      .reset       (reset),
      .load        (load1),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .s1_valid    (s1_valid),
      .s1_data     (s1_data)
   );

   fbsgc_span u_span (
      .clock    (clock),
      .reset    (reset),
      .ctl      (span_ctl),
      .s1_valid (s1_valid),
      .s1_data  (s1_data),
      .s2_valid (s2_valid),
      .s3_valid (s3_valid),
      .s3_data  (s3_data)
   );

   fbsgc_class u_class (
      .clock       (clock),
      .reset       (reset),
      .load        (load4),
      .s3_valid    (s3_valid),
      .s3_data     (s3_data),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   `FBSGC_ASSERT_SAME(a_stall_only_when_full, req_stall, s1_valid && s2_valid && s3_valid && rsp_valid, "request stalled while a stage was empty")
   `FBSGC_ASSERT_SAME(a_bad_volume_zero, rsp_valid && !rsp_payload.volume_ok, rsp_payload.fat_variant == VARIANT_FAT12 && rsp_payload.root_dir_sectors == 13'd0 && rsp_payload.fat_sectors == 32'd0 && rsp_payload.total_sectors == 32'd0 && rsp_payload.data_sectors == 32'd0 && rsp_payload.data_clusters == 32'd0, "bad volume result has nonzero fields")
   `FBSGC_ASSERT_SAME(a_data_below_total, rsp_valid && rsp_payload.volume_ok, rsp_payload.data_sectors < rsp_payload.total_sectors, "good volume with data not below total")
   `FBSGC_ASSERT_SAME(a_variant_matches, rsp_valid && rsp_payload.volume_ok, (rsp_payload.fat_variant == VARIANT_FAT12) == (rsp_payload.data_clusters < FAT12_LIMIT) && (rsp_payload.fat_variant == VARIANT_FAT32) == (rsp_payload.data_clusters >= FAT16_LIMIT), "FAT variant disagrees with cluster count")

endmodule

### rtl/core/fbsgc_check.sv
// ----------------------------------------------------------------------------
// FAT boot sector geometry check, field check stage
// Validates the parameter block and picks the FAT size, total and root size.
// ----------------------------------------------------------------------------
module fbsgc_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic             req_valid,
   input  fbsgc_pkg::req_type req_payload,
   output logic             s1_valid,
   output fbsgc_pkg::s1_type s1_data
);
   import fbsgc_pkg::*;

   logic        valid_ff;
   s1_type      s1_in;
   s1_type      s1_ff;
   logic [22:0] round_sum;
   logic        sig_ok;
   logic        bps_ok;
   logic        spc_ok;
   logic        fat_ok;
   logic        count_ok;
   logic [7:0]  spc;

   assign spc = req_payload.sectors_per_cluster;

   always_comb begin
      sig_ok   = req_payload.boot_signature == SIG_WORD;
      bps_ok   = req_payload.bytes_per_sector == SECTOR_512  ||
                 req_payload.bytes_per_sector == SECTOR_1024 ||
                 req_payload.bytes_per_sector == SECTOR_2048 ||
                 req_payload.bytes_per_sector == SECTOR_4096;
      spc_ok   = spc != 8'd0 && (spc & (spc - 8'd1)) == 8'd0;
      fat_ok   = req_payload.fat_size_short != 16'd0 || req_payload.fat_size_long != 32'd0;
      count_ok = (req_payload.fat_count == 8'd1 || req_payload.fat_count == 8'd2) &&
                 req_payload.reserved_sectors != 16'd0;

      round_sum = {2'b00, req_payload.root_entries, {DIR_ENTRY_SHIFT{1'b0}}} +
                  {7'd0, req_payload.bytes_per_sector} - 23'd1;

      s1_in      = '0;
      s1_in.good = sig_ok && bps_ok && spc_ok && fat_ok && count_ok;
      s1_in.rsv  = req_payload.reserved_sectors;

      unique case (req_payload.bytes_per_sector)
         SECTOR_512:  s1_in.root = round_sum[21:9];
         SECTOR_1024: s1_in.root = round_sum[22:10];
         SECTOR_2048: s1_in.root = {1'b0, round_sum[22:11]};
         SECTOR_4096: s1_in.root = {2'b00, round_sum[22:12]};
         default:     s1_in.root = '0;
      endcase

      s1_in.fat = (req_payload.fat_size_short != 16'd0) ?
                  {16'd0, req_payload.fat_size_short} : req_payload.fat_size_long;
      s1_in.tot = (req_payload.total_short != 16'd0) ?
                  {16'd0, req_payload.total_short} : req_payload.total_long;
      s1_in.fat_mult = (req_payload.fat_count == 8'd2) ? {s1_in.fat[30:0], 1'b0} : s1_in.fat;

      for (int i = 0; i < 8; i++) begin
         if (spc[i]) begin
            s1_in.spc_shift = 3'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_data  = s1_ff;

endmodule

### rtl/core/fbsgc_span.sv
// ----------------------------------------------------------------------------
// FAT boot sector geometry check, data span stages
// Sums the metadata sectors, then forms data sectors and data clusters.
// ----------------------------------------------------------------------------
module fbsgc_span (
   input  logic                   clock,
   input  logic                   reset,
   input  fbsgc_pkg::span_ctl_type ctl,
   input  logic                   s1_valid,
   input  fbsgc_pkg::s1_type      s1_data,
   output logic                   s2_valid,
   output logic                   s3_valid,
   output fbsgc_pkg::s3_type      s3_data
);
   import fbsgc_pkg::*;

   logic   s2_valid_ff;
   logic   s3_valid_ff;
   s2_type s2_in;
   s2_type s2_ff;
   s3_type s3_in;
   s3_type s3_ff;

   always_comb begin
      s2_in.good      = s1_data.good;
      s2_in.root      = s1_data.root;
      s2_in.fat       = s1_data.fat;
      s2_in.tot       = s1_data.tot;
      s2_in.spc_shift = s1_data.spc_shift;
      s2_in.meta      = {16'd0, s1_data.rsv} + {19'd0, s1_data.root} + s1_data.fat_mult;
   end

   always_comb begin
      s3_in.good = s2_ff.good;
      s3_in.root = s2_ff.root;
      s3_in.fat  = s2_ff.fat;
      s3_in.tot  = s2_ff.tot;
      s3_in.data = s2_ff.tot - s2_ff.meta;
      s3_in.clus = s3_in.data >> s2_ff.spc_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (ctl.load_a) begin
            s2_valid_ff <= s1_valid;
         end
         if (ctl.load_b) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_a) begin
         s2_ff <= s2_in;
      end
      if (ctl.load_b) begin
         s3_ff <= s3_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s3_valid = s3_valid_ff;
   assign s3_data  = s3_ff;

endmodule

### rtl/core/fbsgc_class.sv
// ----------------------------------------------------------------------------
// FAT boot sector geometry check, classify stage
// Makes the final validity decision, picks the FAT variant and holds the
// result beat.
// ----------------------------------------------------------------------------
module fbsgc_class (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              s3_valid,
   input  fbsgc_pkg::s3_type s3_data,
   output logic              rsp_valid,
   output fbsgc_pkg::rsp_type rsp_payload
);
   import fbsgc_pkg::*;

   logic    valid_ff;
   rsp_type rsp_in;
   rsp_type rsp_ff;

   always_comb begin
      rsp_in = '0;
      if (s3_data.good && s3_data.data < s3_data.tot) begin
         rsp_in.volume_ok        = 1'b1;
         rsp_in.root_dir_sectors = s3_data.root;
         rsp_in.fat_sectors      = s3_data.fat;
         rsp_in.total_sectors    = s3_data.tot;
         rsp_in.data_sectors     = s3_data.data;
         rsp_in.data_clusters    = s3_data.clus;
         if (s3_data.clus < FAT12_LIMIT) begin
            rsp_in.fat_variant = VARIANT_FAT12;
         end else if (s3_data.clus < FAT16_LIMIT) begin
            rsp_in.fat_variant = VARIANT_FAT16;
         end else begin
            rsp_in.fat_variant = VARIANT_FAT32;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= s3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
